// File: hdl/emhq_pkg.sv
// ----------------------------------------------------------------------------
// emhq_pkg
// Shared types, codes and defaults for the event min-heap queue.
// ----------------------------------------------------------------------------
package emhq_pkg;

    // Default sizing, used as the parameter defaults of the modules
    localparam int CAPACITY_DEF = 1024;
    localparam int PID_BITS_DEF = 8;

    // Fixed field widths
    localparam int TIME_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_ARRIVAL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IO_DONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CMP,
        ST_DN_LAST,
        ST_DN_RIGHT,
        ST_DN_SEL,
        ST_DN_CMP,
        ST_PLACE,
        ST_DONE
    } emhq_state_t;

endpackage

// File: hdl/emhq_cmp.sv
// ----------------------------------------------------------------------------
// emhq_cmp
// Event priority compare: high when event a must leave after event b.
// ----------------------------------------------------------------------------
module emhq_cmp #(
    parameter int PID_BITS = emhq_pkg::PID_BITS_DEF
) (
    input  logic [emhq_pkg::TIME_W+emhq_pkg::KIND_W+PID_BITS-1:0] a,
    input  logic [emhq_pkg::TIME_W+emhq_pkg::KIND_W+PID_BITS-1:0] b,
    output logic                                                   after
);

    localparam int EV_W = emhq_pkg::TIME_W + emhq_pkg::KIND_W + PID_BITS;

    logic [emhq_pkg::TIME_W-1:0] a_time;
    logic [emhq_pkg::TIME_W-1:0] b_time;
    logic [emhq_pkg::KIND_W-1:0] a_kind;
    logic [emhq_pkg::KIND_W-1:0] b_kind;
    logic [PID_BITS-1:0]         a_pid;
    logic [PID_BITS-1:0]         b_pid;
    logic                        a_early;
    logic                        b_early;

    // Split the packed events into time, kind and pid
    assign a_time = a[EV_W-1 -: emhq_pkg::TIME_W];
    assign b_time = b[EV_W-1 -: emhq_pkg::TIME_W];
    assign a_kind = a[PID_BITS +: emhq_pkg::KIND_W];
    assign b_kind = b[PID_BITS +: emhq_pkg::KIND_W];
    assign a_pid  = a[PID_BITS-1:0];
    assign b_pid  = b[PID_BITS-1:0];

    // Arrival and I/O complete rank ahead of a timeout
    assign a_early = (a_kind == emhq_pkg::KIND_ARRIVAL) || (a_kind == emhq_pkg::KIND_IO_DONE);
    assign b_early = (b_kind == emhq_pkg::KIND_ARRIVAL) || (b_kind == emhq_pkg::KIND_IO_DONE);

    // Order by time, then kind class, then pid
    always_comb
    begin
        if (a_time != b_time)
        begin
            after = (a_time > b_time);
        end
        else if ((a_kind == emhq_pkg::KIND_TIMEOUT) && b_early)
        begin
            after = 1'b1;
        end
        else if ((b_kind == emhq_pkg::KIND_TIMEOUT) && a_early)
        begin
            after = 1'b0;
        end
        else
        begin
            after = (a_pid > b_pid);
        end
    end

endmodule

// File: hdl/emhq_mem.sv
// ----------------------------------------------------------------------------
// emhq_mem
// Heap storage: one write and one registered read per cycle, 1-based index.
// ----------------------------------------------------------------------------
module emhq_mem #(
    parameter int CAPACITY = emhq_pkg::CAPACITY_DEF,
    parameter int EV_W     = emhq_pkg::TIME_W + emhq_pkg::KIND_W + emhq_pkg::PID_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(CAPACITY+1)-1:0]    wr_idx,
    input  logic [EV_W-1:0]                  wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(CAPACITY+1)-1:0]    rd_idx,
    output logic [EV_W-1:0]                  rd_data
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    logic [EV_W-1:0]   mem [CAPACITY];
    logic [CNT_W-1:0]  wr_off;
    logic [CNT_W-1:0]  rd_off;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // Map the 1-based heap index onto the array
    assign wr_off  = wr_idx - 1'b1;
    assign rd_off  = rd_idx - 1'b1;
    assign wr_addr = wr_off[ADDR_W-1:0];
    assign rd_addr = rd_off[ADDR_W-1:0];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/event_min_heap_queue_core.sv
// ----------------------------------------------------------------------------
// event_min_heap_queue_core
// Binary min-heap of timed events with push and pop, one result per item.
// Push sifts the new event up from a hole at the end; pop moves the last
//   event to the root and sifts it down toward the earlier child.
// One item at a time, with the single memory read port and the shared comparator;
//   results sit in an output register, and a held result keeps the block in ST_DONE.
// Reset clears the count and the control; heap contents are left undefined.
// ----------------------------------------------------------------------------
module event_min_heap_queue_core #(
    parameter int CAPACITY = emhq_pkg::CAPACITY_DEF,
    parameter int PID_BITS = emhq_pkg::PID_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic [emhq_pkg::TIME_W-1:0]         event_time,
    input  logic [emhq_pkg::KIND_W-1:0]         event_kind,
    input  logic [PID_BITS-1:0]                 event_pid,
    // Output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [emhq_pkg::STATUS_W-1:0]       status,
    output logic [emhq_pkg::TIME_W-1:0]         head_time,
    output logic [emhq_pkg::KIND_W-1:0]         head_kind,
    output logic [PID_BITS-1:0]                 head_pid,
    output logic                                head_valid,
    output logic [$clog2(CAPACITY+1)-1:0]       entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EV_W  = emhq_pkg::TIME_W + emhq_pkg::KIND_W + PID_BITS;
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ROOT_IDX = CNT_W'(1);

    // Sequencer state
    emhq_pkg::emhq_state_t state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cidx_reg, cidx_next;
    logic              pop_reg, pop_next;
    logic [emhq_pkg::STATUS_W-1:0] stat_reg, stat_next;
    logic              hval_reg, hval_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers
    logic [EV_W-1:0]   ev_reg, ev_next;
    logic [EV_W-1:0]   left_reg, left_next;
    logic [EV_W-1:0]   child_reg, child_next;
    logic [EV_W-1:0]   head_reg, head_next;
    logic [EV_W-1:0]   root_reg, root_next;
    logic [EV_W-1:0]   out_ev_reg, out_ev_next;
    logic [emhq_pkg::STATUS_W-1:0] out_stat_reg, out_stat_next;
    logic              out_hval_reg, out_hval_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;

    // Memory port
    logic              wr_en;
    logic [CNT_W-1:0]  wr_idx;
    logic [EV_W-1:0]   wr_data;
    logic              rd_en;
    logic [CNT_W-1:0]  rd_idx;
    logic [EV_W-1:0]   rd_data;

    // Shared comparator
    logic [EV_W-1:0]   cmp_a;
    logic [EV_W-1:0]   cmp_b;
    logic              cmp_after;

    // Index arithmetic
    logic [EV_W-1:0]   in_ev;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W:0]    two_idx;
    logic [CNT_W:0]    two_cidx;
    logic [CNT_W:0]    count_ext;
    logic [CNT_W-1:0]  parent_idx;
    logic [CNT_W-1:0]  left_idx;
    logic [CNT_W-1:0]  right_idx;
    logic [CNT_W-1:0]  cleft_idx;

    assign in_ev      = {event_time, event_kind, event_pid};
    assign cnt_inc    = count_reg + 1'b1;
    assign two_idx    = {idx_reg, 1'b0};
    assign two_cidx   = {cidx_reg, 1'b0};
    assign count_ext  = {1'b0, count_reg};
    assign parent_idx = {1'b0, idx_reg[CNT_W-1:1]};
    assign left_idx   = {idx_reg[CNT_W-2:0], 1'b0};
    assign right_idx  = {idx_reg[CNT_W-2:0], 1'b1};
    assign cleft_idx  = {cidx_reg[CNT_W-2:0], 1'b0};

    emhq_mem #(
        .CAPACITY (CAPACITY),
        .EV_W     (EV_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    emhq_cmp #(
        .PID_BITS (PID_BITS)
    ) u_cmp (
        .a     (cmp_a),
        .b     (cmp_b),
        .after (cmp_after)
    );

    // Steer the comparator by step
    always_comb
    begin
        unique case (state_reg)
            emhq_pkg::ST_UP_CMP:
            begin
                cmp_a = rd_data;
                cmp_b = ev_reg;
            end
            emhq_pkg::ST_DN_SEL:
            begin
                cmp_a = left_reg;
                cmp_b = rd_data;
            end
            default:
            begin
                cmp_a = ev_reg;
                cmp_b = child_reg;
            end
        endcase
    end

    // Next state and memory control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cidx_next      = cidx_reg;
        pop_next       = pop_reg;
        stat_next      = stat_reg;
        hval_next      = hval_reg;
        out_valid_next = out_valid_reg;
        ev_next        = ev_reg;
        left_next      = left_reg;
        child_next     = child_reg;
        head_next      = head_reg;
        out_ev_next    = out_ev_reg;
        out_stat_next  = out_stat_reg;
        out_hval_next  = out_hval_reg;
        out_cnt_next   = out_cnt_reg;
        wr_en          = 1'b0;
        wr_idx         = idx_reg;
        wr_data        = ev_reg;
        rd_en          = 1'b0;
        rd_idx         = left_idx;

        // Drop the result once transferred
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            emhq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    pop_next  = opcode;
                    stat_next = emhq_pkg::STAT_OK;
                    hval_next = 1'b1;
                    if (opcode == emhq_pkg::OP_PUSH)
                    begin
                        ev_next = in_ev;
                        if (count_reg == CAP_CNT)
                        begin
                            stat_next  = emhq_pkg::STAT_FULL;
                            state_next = emhq_pkg::ST_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            // First event lands at the root
                            count_next = cnt_inc;
                            wr_en      = 1'b1;
                            wr_idx     = ROOT_IDX;
                            wr_data    = in_ev;
                            state_next = emhq_pkg::ST_DONE;
                        end
                        else
                        begin
                            // Open a hole at the end, fetch its parent
                            count_next = cnt_inc;
                            idx_next   = cnt_inc;
                            rd_en      = 1'b1;
                            rd_idx     = {1'b0, cnt_inc[CNT_W-1:1]};
                            state_next = emhq_pkg::ST_UP_CMP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            stat_next  = emhq_pkg::STAT_EMPTY;
                            hval_next  = 1'b0;
                            head_next  = '0;
                            state_next = emhq_pkg::ST_DONE;
                        end
                        else
                        begin
                            head_next  = root_reg;
                            count_next = count_reg - 1'b1;
                            idx_next   = ROOT_IDX;
                            if (count_reg == ROOT_IDX)
                            begin
                                state_next = emhq_pkg::ST_DONE;
                            end
                            else
                            begin
                                // Fetch the last event to move to the root
                                rd_en      = 1'b1;
                                rd_idx     = count_reg;
                                state_next = emhq_pkg::ST_DN_LAST;
                            end
                        end
                    end
                end
            end

            emhq_pkg::ST_UP_CMP:
            begin
                if (cmp_after)
                begin
                    // Move the parent down and climb one level
                    wr_en    = 1'b1;
                    wr_data  = rd_data;
                    idx_next = parent_idx;
                    if (parent_idx == ROOT_IDX)
                    begin
                        state_next = emhq_pkg::ST_PLACE;
                    end
                    else
                    begin
                        rd_en  = 1'b1;
                        rd_idx = {1'b0, parent_idx[CNT_W-1:1]};
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = emhq_pkg::ST_DONE;
                end
            end

            emhq_pkg::ST_DN_LAST:
            begin
                ev_next = rd_data;
                if (two_idx > count_ext)
                begin
                    state_next = emhq_pkg::ST_PLACE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_idx     = left_idx;
                    state_next = emhq_pkg::ST_DN_RIGHT;
                end
            end

            emhq_pkg::ST_DN_RIGHT:
            begin
                left_next = rd_data;
                if (two_idx < count_ext)
                begin
                    rd_en      = 1'b1;
                    rd_idx     = right_idx;
                    state_next = emhq_pkg::ST_DN_SEL;
                end
                else
                begin
                    child_next = rd_data;
                    cidx_next  = left_idx;
                    state_next = emhq_pkg::ST_DN_CMP;
                end
            end

            emhq_pkg::ST_DN_SEL:
            begin
                // Take the right child only when strictly ahead
                if (cmp_after)
                begin
                    child_next = rd_data;
                    cidx_next  = right_idx;
                end
                else
                begin
                    child_next = left_reg;
                    cidx_next  = left_idx;
                end
                state_next = emhq_pkg::ST_DN_CMP;
            end

            emhq_pkg::ST_DN_CMP:
            begin
                wr_en = 1'b1;
                if (cmp_after)
                begin
                    // Move the child up and descend one level
                    wr_data  = child_reg;
                    idx_next = cidx_reg;
                    if (two_cidx > count_ext)
                    begin
                        state_next = emhq_pkg::ST_PLACE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_idx     = cleft_idx;
                        state_next = emhq_pkg::ST_DN_RIGHT;
                    end
                end
                else
                begin
                    state_next = emhq_pkg::ST_DONE;
                end
            end

            emhq_pkg::ST_PLACE:
            begin
                wr_en      = 1'b1;
                state_next = emhq_pkg::ST_DONE;
            end

            emhq_pkg::ST_DONE:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_cnt_next   = count_reg;
                    out_ev_next    = pop_reg ? head_reg : root_reg;
                    out_hval_next  = pop_reg ? hval_reg : 1'b1;
                    state_next     = emhq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = emhq_pkg::ST_IDLE;
            end
        endcase
    end

    // Track the root copy on every write to the top of the heap
    always_comb
    begin
        root_next = root_reg;
        if (wr_en && (wr_idx == ROOT_IDX))
        begin
            root_next = wr_data;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= emhq_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pop_reg       <= 1'b0;
            stat_reg      <= emhq_pkg::STAT_OK;
            hval_reg      <= 1'b0;
            idx_reg       <= '0;
            cidx_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            pop_reg       <= pop_next;
            stat_reg      <= stat_next;
            hval_reg      <= hval_next;
            idx_reg       <= idx_next;
            cidx_reg      <= cidx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ev_reg       <= ev_next;
        left_reg     <= left_next;
        child_reg    <= child_next;
        head_reg     <= head_next;
        root_reg     <= root_next;
        out_ev_reg   <= out_ev_next;
        out_stat_reg <= out_stat_next;
        out_hval_reg <= out_hval_next;
        out_cnt_reg  <= out_cnt_next;
    end

    // Drive the ports
    assign in_ready    = (state_reg == emhq_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_stat_reg;
    assign head_time   = out_ev_reg[EV_W-1 -: emhq_pkg::TIME_W];
    assign head_kind   = out_ev_reg[PID_BITS +: emhq_pkg::KIND_W];
    assign head_pid    = out_ev_reg[PID_BITS-1:0];
    assign head_valid  = out_hval_reg;
    assign entry_count = out_cnt_reg;

endmodule
